>>> design/bist_pkg.sv
// Shared request and response types, command codes and control structs for the set table.
`timescale 1ns / 1ps

package bist_pkg;

    // Request codes carried in the cmd field.
    localparam logic [1:0] CMD_LOOKUP     = 2'd0;
    localparam logic [1:0] CMD_INSERT     = 2'd1;
    localparam logic [1:0] CMD_INSERT_NEW = 2'd2;
    localparam logic [1:0] CMD_REMOVE     = 2'd3;

    // Width of the occupancy field in a response.
    localparam int OCC_W = 5;

    // One request.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
    } t_req;

    // One response.
    typedef struct packed {
        logic             hit;
        logic             rejected;
        logic [OCC_W-1:0] occupancy;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;   // write an empty slot during the clearing pass
        logic start;    // capture a new request and reset the search flags
        logic rd_en;    // read the slot at the sequencer address
        logic commit;   // apply the update and load the response register
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // the response register can take a new response
    } t_sts;

endpackage

>>> design/bounded_integer_set_table.sv
// Top level of the bounded integer set table: controller and datapath.
`timescale 1ns / 1ps

// Set table holding up to CAPACITY signed 32-bit keys in a slot memory with one
// write port and one read port. Each request (lookup, insert, insert if new, remove
// one) scans every slot, one memory read per cycle, and then commits its update and
// response; the next request is taken only after that commit, a pace set by the
// one read port of the slot memory. After reset a clearing pass marks all CAPACITY
// slots empty, one per cycle, and no request is taken until it ends.
// The finished response waits in an output register; the scan of the next request
// may run meanwhile, and its commit waits until that register is free.
// Occupancy reports the entry count masked to five bits.
module bounded_integer_set_table #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bist_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bist_pkg::t_rsp o_out_data
);
    import bist_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    t_ctl          ctl;
    t_sts          sts;
    logic [IW-1:0] addr;

    bist_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_addr     (addr)
    );

    bist_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_addr      (addr),
        .i_req       (i_in_data),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_out_data)
    );

endmodule

>>> design/bist_ctrl.sv
// Controller: clearing pass after reset and the slot scan sequencer for each request.
`timescale 1ns / 1ps

module bist_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bist_pkg::t_sts                i_sts,
    output bist_pkg::t_ctl                o_ctl,
    output logic [$clog2(CAPACITY)-1:0]   o_addr
);
    import bist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] LAST_ADDR = IW'(CAPACITY - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_LAST   = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;

    // Next state, slot counter and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                n_cnt        = r_cnt + IW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.rd_en = 1'b1;
                n_cnt       = r_cnt + IW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // A request transfer is taken only while idle.
    assign o_in_stall = (r_state != S_IDLE);
    assign o_addr     = r_cnt;

endmodule

>>> design/bist_dpath.sv
// Datapath: slot memory, key compare, search flags, entry count and response register.
`timescale 1ns / 1ps

module bist_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bist_pkg::t_ctl                i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_addr,
    input  bist_pkg::t_req                i_req,
    output bist_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bist_pkg::t_rsp                o_rsp
);
    import bist_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Each slot holds a valid bit above the 32-bit value.
    logic [32:0]   mem [CAPACITY];

    logic [1:0]    r_cmd;
    logic signed [31:0] r_key;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [32:0]   r_rd_word;
    logic          r_match_found;
    logic [IW-1:0] r_match_idx;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    t_rsp          r_rsp;

    logic          slot_match;
    logic          slot_free;
    logic          do_ins;
    logic          ins_ok;
    logic          do_rem;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [32:0]   wr_word;

    // Slot memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= mem[i_addr];
        end
    end

    // Compare of the slot read in the previous cycle.
    assign slot_match = r_rd_vld && r_rd_word[32] && (r_rd_word[31:0] == r_key);
    assign slot_free  = r_rd_vld && !r_rd_word[32];

    // Request decode at commit time.
    assign do_ins = (r_cmd == CMD_INSERT) || ((r_cmd == CMD_INSERT_NEW) && !r_match_found);
    assign ins_ok = do_ins && r_free_found;
    assign do_rem = (r_cmd == CMD_REMOVE) && r_match_found;

    // Write port: empty slots during the clearing pass, else the committed update.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_addr;
        wr_word = '0;
        if (i_ctl.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_ctl.commit && ins_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_free_idx;
            wr_word = {1'b1, r_key};
        end else if (i_ctl.commit && do_rem) begin
            wr_en   = 1'b1;
            wr_addr = r_match_idx;
        end
    end

    // Entry count after this request.
    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // Request capture and search flags; the lowest matching and lowest free slot win.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_count       <= '0;
        end else begin
            r_rd_vld <= i_ctl.rd_en;
            if (i_ctl.start) begin
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else begin
                if (slot_match && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
                if (slot_free && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_ctl.commit) begin
                r_count <= n_count;
            end
        end
    end

    // Payload registers of the current request.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_addr;
        if (i_ctl.start) begin
            r_cmd <= i_req.cmd;
            r_key <= i_req.key;
        end
        if (slot_match && !r_match_found) begin
            r_match_idx <= r_rd_idx;
        end
        if (slot_free && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
    end

    // Response register; a waiting response holds until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_rsp.hit       <= r_match_found;
            r_rsp.rejected  <= do_ins && !r_free_found;
            r_rsp.occupancy <= OCC_W'(n_count);
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule
